>>> rtl/core/dmmlcd_pkg.sv
// Shared types, codes and segment lookup for the multimeter LCD packet decoder.
package dmmlcd_pkg;

	localparam int PktBytes  = 14;
	localparam int StoreBytes = PktBytes - 1;
	localparam int QDepth    = 2;

	// register map
	localparam logic REG_USER_SYMBOL_MODE = 1'b0;

	typedef logic [3:0] nib_t;
	typedef logic [PktBytes-1:0][3:0] pkt_t;

	// front to queue
	typedef struct packed {
		logic push;
		pkt_t pkt;
	} q_wr_t;

	// queue to back
	typedef struct packed {
		logic avail;
		pkt_t pkt;
	} q_rd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FLAGS = 2'd1,
		ST_DIGIT = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		Q_NONE  = 4'd0,
		Q_VOLT  = 4'd1,
		Q_AMP   = 4'd2,
		Q_OHM   = 4'd3,
		Q_HZ    = 4'd4,
		Q_FARAD = 4'd5,
		Q_CONT  = 4'd6,
		Q_DUTY  = 4'd7,
		Q_DEGC  = 4'd8,
		Q_DEGF  = 4'd9
	} quantity_t;

	typedef enum logic [2:0] {
		USM_NONE   = 3'd0,
		USM_SYM0_C = 3'd1,
		USM_SYM1_C = 3'd2,
		USM_SYM2_C = 3'd3,
		USM_SYM1_F = 3'd4
	} usm_t;

	// overlimit display pattern
	localparam logic [6:0] OL_D0 = 7'h00;
	localparam logic [6:0] OL_D1 = 7'h7d;
	localparam logic [6:0] OL_D2 = 7'h68;
	localparam logic [6:0] OL_D3 = 7'h00;

	// 7-segment code to digit; bit 4 is the valid mark
	function automatic logic [4:0] seg_decode(input logic [6:0] code);
		logic [4:0] r;
		unique case (code)
			7'h7d:   r = {1'b1, 4'd0};
			7'h05:   r = {1'b1, 4'd1};
			7'h5b:   r = {1'b1, 4'd2};
			7'h1f:   r = {1'b1, 4'd3};
			7'h27:   r = {1'b1, 4'd4};
			7'h3e:   r = {1'b1, 4'd5};
			7'h7e:   r = {1'b1, 4'd6};
			7'h15:   r = {1'b1, 4'd7};
			7'h7f:   r = {1'b1, 4'd8};
			7'h3f:   r = {1'b1, 4'd9};
			default: r = {1'b0, 4'd0};
		endcase
		return r;
	endfunction

	// true when more than one bit is set
	function automatic logic multi_hot(input logic [5:0] v);
		return (v & (v - 6'd1)) != 6'd0;
	endfunction

endpackage

>>> rtl/core/dmmlcd_front.sv
// Front end: sequence tracking and nibble capture, hands full packets to the queue.
module dmmlcd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	input  logic               q_full,
	output dmmlcd_pkg::q_wr_t  q_wr
);
	import dmmlcd_pkg::*;

	logic [3:0] pos_q;
	nib_t       nib_q [StoreBytes];
	logic [3:0] seq;
	nib_t       low;
	logic       take;
	logic       restart;
	logic       in_order;
	logic       last;

	assign seq      = rx_byte[7:4];
	assign low      = rx_byte[3:0];
	assign in_stall = q_full;
	assign take     = in_valid && !in_stall;

	assign restart  = (seq == 4'd1);
	assign in_order = (pos_q != 4'd0) && ({1'b0, seq} == ({1'b0, pos_q} + 5'd1));
	assign last     = (seq == 4'(PktBytes));

	// byte position tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 4'd0;
		end else if (take) begin
			if (restart) begin
				pos_q <= 4'd1;
			end else if (!in_order || last) begin
				pos_q <= 4'd0;
			end else begin
				pos_q <= pos_q + 4'd1;
			end
		end
	end

	// nibble store, no reset
	always_ff @(posedge clk) begin
		if (take) begin
			if (restart) begin
				nib_q[0] <= low;
			end else if (in_order && !last && pos_q < 4'(StoreBytes)) begin
				nib_q[pos_q] <= low;
			end
		end
	end

	// packet assembly for the queue
	always_comb begin
		q_wr.push = take && !restart && in_order && last;
		for (int i = 0; i < StoreBytes; i++) begin
			q_wr.pkt[i] = nib_q[i];
		end
		q_wr.pkt[PktBytes-1] = low;
	end

endmodule

>>> rtl/core/dmmlcd_queue.sv
// Short packet queue between front and back ends.
module dmmlcd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  dmmlcd_pkg::q_wr_t  q_wr,
	input  logic               pop,
	output dmmlcd_pkg::q_rd_t  q_rd,
	output logic               full
);
	import dmmlcd_pkg::*;

	localparam int PtrW = $clog2(QDepth);

	pkt_t            mem_q [QDepth];
	logic [PtrW-1:0] wptr_q;
	logic [PtrW-1:0] rptr_q;
	logic [PtrW:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full       = (cnt_q == (PtrW+1)'(QDepth));
	assign q_rd.avail = (cnt_q != '0);
	assign q_rd.pkt   = mem_q[rptr_q];
	assign do_push    = q_wr.push && !full;
	assign do_pop     = pop && q_rd.avail;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PtrW'(QDepth - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PtrW'(QDepth - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= q_wr.pkt;
		end
	end

endmodule

>>> rtl/core/dmmlcd_back.sv
// Back end: decodes one packet into a reading and holds it in the output register.
module dmmlcd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  dmmlcd_pkg::q_rd_t  q_rd,
	output logic               pop,
	input  logic [2:0]         user_symbol_mode,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic               over_limit,
	output logic               negative,
	output logic [13:0]        magnitude,
	output logic signed [5:0]  exponent,
	output logic [3:0]         quantity,
	output logic [5:0]         mode_flags,
	output logic               low_battery,
	output logic [3:0]         user_symbols
);
	import dmmlcd_pkg::*;

	pkt_t              nb;
	logic [6:0]        db [4];
	logic [4:0]        dd [4];
	logic              ol;
	logic              neg;
	logic              bad_digit;
	logic              bad_flags;
	logic [13:0]       mag;
	logic signed [5:0] exp_v;
	quantity_t         quant;
	status_t           stat;
	logic [5:0]        flags;
	logic              load;

	logic              valid_q;
	status_t           status_q;
	logic              ol_q;
	logic              neg_q;
	logic [13:0]       mag_q;
	logic signed [5:0] exp_q;
	quantity_t         quant_q;
	logic [5:0]        flags_q;
	logic              lowbat_q;
	logic [3:0]        usym_q;

	assign nb   = q_rd.pkt;
	assign load = q_rd.avail && (!valid_q || !out_stall);
	assign pop  = load;

	// digit extraction and lookup
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			db[i] = {nb[1 + 2*i][2:0], nb[2 + 2*i]};
			dd[i] = seg_decode(db[i]);
		end
	end

	// reading decode
	always_comb begin
		neg       = nb[1][3];
		ol        = (db[0] == OL_D0) && (db[1] == OL_D1) && (db[2] == OL_D2) &&
		            (db[3] == OL_D3);
		bad_digit = 1'b0;
		mag       = '0;
		exp_v     = '0;
		if (ol) begin
			neg = 1'b0;
		end else begin
			bad_digit = !(dd[0][4] && dd[1][4] && dd[2][4] && dd[3][4]);
			if (!bad_digit) begin
				mag = 14'(dd[0][3:0]) * 14'd1000 + 14'(dd[1][3:0]) * 14'd100 +
				      14'(dd[2][3:0]) * 14'd10 + 14'(dd[3][3:0]);
			end
			// decimal point
			if (nb[3][3]) begin
				exp_v = -6'sd3;
			end else if (nb[5][3]) begin
				exp_v = -6'sd2;
			end else if (nb[7][3]) begin
				exp_v = -6'sd1;
			end
			// SI prefixes: nano, micro, milli, kilo, mega
			if (nb[9][2]) exp_v = exp_v - 6'sd9;
			if (nb[9][3]) exp_v = exp_v - 6'sd6;
			if (nb[10][3]) exp_v = exp_v - 6'sd3;
			if (nb[9][1]) exp_v = exp_v + 6'sd3;
			if (nb[10][1]) exp_v = exp_v + 6'sd6;
		end

		// quantity, last lit flag wins
		quant = Q_NONE;
		if (nb[12][2]) quant = Q_VOLT;
		if (nb[12][3]) quant = Q_AMP;
		if (nb[11][2]) quant = Q_OHM;
		if (nb[12][1]) quant = Q_HZ;
		if (nb[11][3]) quant = Q_FARAD;
		if (nb[10][0]) begin
			quant = Q_CONT;
			mag   = ol ? 14'd0 : 14'd1;
			ol    = 1'b0;
			neg   = 1'b0;
			exp_v = '0;
		end
		if (nb[9][0]) quant = Q_VOLT;
		if (nb[10][2]) quant = Q_DUTY;

		// temperature override from user symbols
		case (user_symbol_mode)
			USM_SYM0_C: if (nb[13][0]) quant = Q_DEGC;
			USM_SYM1_C: if (nb[13][1]) quant = Q_DEGC;
			USM_SYM2_C: if (nb[13][2]) quant = Q_DEGC;
			USM_SYM1_F: begin
				if (nb[13][1]) quant = Q_DEGF;
				if (nb[13][2]) quant = Q_DEGC;
			end
			default: ;
		endcase

		flags = {nb[11][1], nb[11][0], nb[9][0], nb[0][1], nb[0][2], nb[0][3]};

		// flag consistency
		bad_flags = multi_hot({1'b0, nb[9][2], nb[9][3], nb[10][3], nb[9][1], nb[10][1]}) ||
		            multi_hot({nb[12][1], nb[11][2], nb[11][3], nb[12][3], nb[12][2],
		                       nb[10][2]}) ||
		            (nb[0][3] && nb[0][2]) || !nb[0][0];
		if (bad_digit) begin
			stat = ST_DIGIT;
		end else if (bad_flags) begin
			stat = ST_FLAGS;
		end else begin
			stat = ST_OK;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= stat;
			ol_q     <= ol;
			neg_q    <= neg;
			mag_q    <= mag;
			exp_q    <= exp_v;
			quant_q  <= quant;
			flags_q  <= flags;
			lowbat_q <= nb[12][0];
			usym_q   <= nb[13];
		end
	end

	assign out_valid    = valid_q;
	assign status       = status_q;
	assign over_limit   = ol_q;
	assign negative     = neg_q;
	assign magnitude    = mag_q;
	assign exponent     = exp_q;
	assign quantity     = quant_q;
	assign mode_flags   = flags_q;
	assign low_battery  = lowbat_q;
	assign user_symbols = usym_q;

endmodule

>>> rtl/core/dmm_lcd_packet_decoder.sv
// Top level of the multimeter LCD packet decoder: register port, front, queue and back.
//
//  port group   direction  transaction
//  in_*         in         one received byte (rx_byte)
//  out_*        out        one decoded reading, after the 14th byte of a packet
//  p*           in/out     register access, user_symbol_mode at byte address 0
//
// One byte is taken every cycle; in_stall rises only while the two-entry packet
// queue is full. A reading is written into the queue on its last byte and is then
// decoded into the output register, where it stays until out_stall is low.
// Reset clears the byte position, queue count, output valid and the register;
// the nibble store needs no clearing since every nibble is written before use.
module dmm_lcd_packet_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic               over_limit,
	output logic               negative,
	output logic [13:0]        magnitude,
	output logic signed [5:0]  exponent,
	output logic [3:0]         quantity,
	output logic [5:0]         mode_flags,
	output logic               low_battery,
	output logic [3:0]         user_symbols,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import dmmlcd_pkg::*;

	logic [2:0] usm_q;
	q_wr_t      q_wr;
	q_rd_t      q_rd;
	logic       q_full;
	logic       q_pop;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_USER_SYMBOL_MODE) ? {29'd0, usm_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usm_q <= 3'd0;
		end else if (psel && penable && pwrite && pready &&
		             paddr[2] == REG_USER_SYMBOL_MODE) begin
			usm_q <= pwdata[2:0];
		end
	end

	dmmlcd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.q_wr     (q_wr)
	);

	dmmlcd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (q_pop),
		.q_rd   (q_rd),
		.full   (q_full)
	);

	dmmlcd_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_rd             (q_rd),
		.pop              (q_pop),
		.user_symbol_mode (usm_q),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.over_limit       (over_limit),
		.negative         (negative),
		.magnitude        (magnitude),
		.exponent         (exponent),
		.quantity         (quantity),
		.mode_flags       (mode_flags),
		.low_battery      (low_battery),
		.user_symbols     (user_symbols)
	);

endmodule
